### hdl/sps_pkg.sv
// Shared types and constants for the segmented prime sieve.
package sps_pkg;
  localparam int unsigned NumberWidth   = 24;
  localparam int unsigned SegmentLength = 64;
  localparam int unsigned BaseLimit     = 4096;

  typedef struct packed {
    logic [NumberWidth-1:0] low_bound;
    logic [NumberWidth-1:0] high_bound;
  } req_t;

  typedef struct packed {
    logic [NumberWidth-1:0] number;
    logic                   is_prime;
    logic                   last;
    logic                   range_error;
  } rsp_t;
endpackage

### hdl/segmented_prime_sieve_unit.sv
// Segmented prime sieve: base sieve and segment bitmap in RAM, driven by a sequencer.
//
// Usage: a request word on req (low and high bound) is taken when req_valid_i
// and req_ready_o are both high. The block then answers with one rsp word per
// number of [low, high] in ascending order, the final one with last set. If high
// is below low or the span exceeds SEGMENT_LENGTH, one error word comes back.
// One request is in work at a time; req_ready_o is high only while idle and the
// output register is empty, so the final word must be taken first.
// Steps: a bit-serial square root of high, a clear of the base RAM entries up
// to that root (capped at BASE_LIMIT) and of the segment entries, then for each
// base index p up to the root: a read of its base entry, and for base primes a
// walk that clears the base multiples from p*p, a divide of low by p, and a walk
// that clears the segment entries of the multiples of p. The output words follow.
// The time a request takes is set mostly by the divides, the base scan and the
// marking walks.
// The rsp word is held in an output register while rsp_ready_i is low; the
// sequencer waits. Reset returns the sequencer to idle; the RAMs need no clear
// since every request rewrites the entries it reads.
module segmented_prime_sieve_unit
  import sps_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH   = sps_pkg::NumberWidth,
  parameter int unsigned SEGMENT_LENGTH = sps_pkg::SegmentLength,
  parameter int unsigned BASE_LIMIT     = sps_pkg::BaseLimit
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sps_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output sps_pkg::rsp_t rsp_o
);
  localparam int unsigned BaseDepth = BASE_LIMIT + 1;
  localparam int unsigned BaseAw    = $clog2(BaseDepth);
  localparam int unsigned SegAw     = (SEGMENT_LENGTH > 1) ? $clog2(SEGMENT_LENGTH) : 1;
  localparam int unsigned W         = NUMBER_WIDTH;
  localparam int unsigned PW        = BaseAw;
  localparam int unsigned SqW       = (W + 1) / 2 + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_BCLR, S_SQRT, S_SCLR, S_BRD, S_BCHK, S_BMARK, S_DIV, S_DIVW,
    S_SMARK, S_FIX, S_ORD, S_OUT, S_ERR
  } state_e;

  state_e               state_q;
  logic [W-1:0]         low_q, high_q;
  logic [W:0]           j_q;
  logic [PW:0]          p_q, lim_q;
  logic [PW+PW+1:0]     m_q;
  logic [SqW-1:0]       r_q;
  logic [4:0]           bit_q;
  logic [PW:0]          idx_q;
  logic [SegAw:0]       k_q;
  logic [SegAw:0]       span_q;
  logic                 rv_q;
  rsp_t                 rsp_q;

  logic                 b_we, b_wd, b_rd;
  logic [BaseAw-1:0]    b_addr;
  logic                 s_we, s_wd, s_rd;
  logic [SegAw-1:0]     s_addr;
  logic                 div_start, div_done;
  logic [W-1:0]         div_quo;

  sps_ram #(.Width(1), .Depth(BaseDepth)) u_base (
    .clk_i, .we_i(b_we), .addr_i(b_addr), .wdata_i(b_wd), .rdata_o(b_rd)
  );
  sps_ram #(.Width(1), .Depth(SEGMENT_LENGTH)) u_seg (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wd), .rdata_o(s_rd)
  );
  sps_divider #(.Width(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(low_q),
    .divisor_i(W'(p_q)), .done_o(div_done), .quotient_o(div_quo)
  );

  logic [W:0]       span_w;
  logic [SqW-1:0]   t_w;
  logic [2*SqW-1:0] tt_w;
  logic [W+PW:0]    first_w;
  logic [W+PW:0]    pp_w;

  always_comb begin
    span_w  = {1'b0, req_i.high_bound} - {1'b0, req_i.low_bound} + 1'b1;
    t_w     = r_q | (SqW'(1) << bit_q);
    tt_w    = t_w * t_w;
    first_w = (W+PW+1)'(div_quo) * (W+PW+1)'(p_q);
    if (first_w < (W+PW+1)'(low_q)) first_w = first_w + (W+PW+1)'(p_q);
    pp_w    = (W+PW+1)'(p_q) * (W+PW+1)'(p_q);
  end

  always_comb begin
    b_we      = 1'b0;
    b_wd      = 1'b1;
    b_addr    = idx_q[BaseAw-1:0];
    s_we      = 1'b0;
    s_wd      = 1'b0;
    s_addr    = k_q[SegAw-1:0];
    div_start = 1'b0;
    unique case (state_q)
      S_BCLR:  begin b_we = 1'b1; b_wd = (idx_q > (PW+1)'(1)) ? 1'b1 : 1'b0; end
      S_SCLR:  begin s_we = 1'b1; s_wd = 1'b1; end
      S_BRD, S_BCHK: b_addr = p_q[BaseAw-1:0];
      S_BMARK: begin
        b_we   = (m_q <= (PW+PW+2)'(lim_q));
        b_wd   = 1'b0;
        b_addr = m_q[BaseAw-1:0];
      end
      S_DIV:   div_start = 1'b1;
      S_SMARK: begin
        s_we   = (j_q <= {1'b0, high_q});
        s_addr = SegAw'(j_q - (W+1)'(low_q));
      end
      S_FIX:   begin s_we = (low_q == '0); end
      default: ;
    endcase
  end

  function automatic logic [PW:0] lim_calc(input logic [SqW-1:0] r);
    if ((SqW > PW + 1) ? (r > SqW'(BASE_LIMIT)) : ((PW+1)'(r) > (PW+1)'(BASE_LIMIT)))
      return (PW+1)'(BASE_LIMIT);
    return (PW+1)'(r);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (req_valid_i && !rv_q) begin
          low_q  <= req_i.low_bound;
          high_q <= req_i.high_bound;
          if (req_i.high_bound < req_i.low_bound || span_w > (W+1)'(SEGMENT_LENGTH)) begin
            state_q <= S_ERR;
          end else begin
            span_q  <= (SegAw+1)'(span_w);
            r_q     <= '0;
            bit_q   <= 5'(SqW - 1);
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if ((2*SqW)'(tt_w) <= (2*SqW)'(high_q)) r_q <= t_w;
          if (bit_q == 5'd0) begin
            state_q <= S_BCLR;
            idx_q   <= '0;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_BCLR: begin
          if (idx_q == lim_calc(r_q)) begin
            lim_q   <= lim_calc(r_q);
            k_q     <= '0;
            state_q <= S_SCLR;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SCLR: begin
          if (k_q == span_q - 1'b1) begin
            p_q     <= (PW+1)'(2);
            state_q <= S_BRD;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_BRD: begin
          if (p_q > lim_q) begin
            state_q <= S_FIX;
            k_q     <= '0;
          end else begin
            state_q <= S_BCHK;
          end
        end
        S_BCHK: begin
          if (b_rd) begin
            m_q     <= (PW+PW+2)'(pp_w);
            state_q <= S_BMARK;
          end else begin
            p_q     <= p_q + 1'b1;
            state_q <= S_BRD;
          end
        end
        S_BMARK: begin
          if (m_q > (PW+PW+2)'(lim_q)) begin
            state_q <= S_DIV;
          end else begin
            m_q <= m_q + (PW+PW+2)'(p_q);
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: if (div_done) begin
          if (first_w > pp_w) j_q <= (W+1)'(first_w);
          else if (pp_w > (W+PW+1)'(high_q)) j_q <= {1'b0, high_q} + 1'b1;
          else j_q <= (W+1)'(pp_w);
          if (first_w > (W+PW+1)'(high_q) && pp_w > (W+PW+1)'(high_q))
            j_q <= {1'b0, high_q} + 1'b1;
          state_q <= S_SMARK;
        end
        S_SMARK: begin
          if (j_q > {1'b0, high_q}) begin
            p_q     <= p_q + 1'b1;
            state_q <= S_BRD;
          end else begin
            j_q <= j_q + (W+1)'(p_q);
          end
        end
        S_FIX: begin
          state_q <= S_ORD;
        end
        S_ORD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!rv_q || rsp_ready_i) begin
            rv_q              <= 1'b1;
            rsp_q.number      <= low_q + W'(k_q);
            rsp_q.is_prime    <= s_rd && ((W+1)'(low_q) + (W+1)'(k_q) > (W+1)'(1));
            rsp_q.last        <= (k_q == span_q - 1'b1);
            rsp_q.range_error <= 1'b0;
            if (k_q == span_q - 1'b1) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_ORD;
            end
          end
        end
        S_ERR: begin
          if (!rv_q || rsp_ready_i) begin
            rv_q              <= 1'b1;
            rsp_q.number      <= low_q;
            rsp_q.is_prime    <= 1'b0;
            rsp_q.last        <= 1'b1;
            rsp_q.range_error <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (rv_q && rsp_ready_i && !((state_q == S_OUT) || (state_q == S_ERR))) rv_q <= 1'b0;
    end
  end

  assign req_ready_o = (state_q == S_IDLE) && !rv_q;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;
endmodule

### hdl/sps_ram.sv
// Generic single-port RAM with registered read.
module sps_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### hdl/sps_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module sps_divider #(
  parameter int unsigned Width = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o
);
  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic [Width-1:0]    quo_q, quo_d;
  logic [Width:0]      rem_q, rem_d;
  logic [Width-1:0]    div_q, div_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [Width:0]      trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[Width-1:0], quo_q[Width-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CntWidth'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

### bench/segmented_prime_sieve_unit_tb.sv
// Self-checking testbench for segmented_prime_sieve_unit: directed and random sieve requests.
module segmented_prime_sieve_unit_tb;
  import sps_pkg::*;

  localparam int unsigned MaxNum = (1 << NumberWidth) - 1;
  localparam longint CycleLimit = 20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  rsp_t   sieve_words[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     steady = 1'b0;

  segmented_prime_sieve_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("segmented_prime_sieve_unit test failed");
      $finish;
    end
  end

  function automatic int unsigned floor_sqrt(int unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r + (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return int'(r);
  endfunction

  // Queue the words a request should produce.
  function automatic void predict_sieve(int unsigned low, int unsigned high);
    bit          base[BaseLimit+1];
    bit          seg[SegmentLength];
    int unsigned lim;
    int unsigned span;
    int unsigned first;
    int unsigned j;
    rsp_t        w;
    low  = low & MaxNum;
    high = high & MaxNum;
    if (high < low || high - low + 1 > SegmentLength) begin
      w = '{number: low[NumberWidth-1:0], is_prime: 1'b0, last: 1'b1, range_error: 1'b1};
      sieve_words = {sieve_words, w};
      return;
    end
    span = high - low + 1;
    lim = floor_sqrt(high);
    if (lim > BaseLimit) lim = BaseLimit;
    for (int i = 0; i <= BaseLimit; i++) base[i] = 1'b1;
    base[0] = 1'b0;
    base[1] = 1'b0;
    for (int unsigned i = 2; i * i <= lim; i++) begin
      if (base[i]) begin
        for (int unsigned k = i * i; k <= lim; k += i) base[k] = 1'b0;
      end
    end
    for (int i = 0; i < SegmentLength; i++) seg[i] = 1'b1;
    for (int unsigned p = 2; p <= lim; p++) begin
      if (base[p]) begin
        first = (low / p) * p;
        if (first < low) first += p;
        j = (first > p * p) ? first : p * p;
        for (; j <= high; j += p) seg[j - low] = 1'b0;
      end
    end
    if (low == 0) seg[0] = 1'b0;
    if (low <= 1 && high >= 1) seg[1 - low] = 1'b0;
    for (int unsigned k = 0; k < span; k++) begin
      w.number      = NumberWidth'(low + k);
      w.is_prime    = seg[k];
      w.last        = (k + 1 == span);
      w.range_error = 1'b0;
      sieve_words = {sieve_words, w};
    end
  endfunction

  task automatic send_bounds(int unsigned low, int unsigned high);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= '{low_bound: low[NumberWidth-1:0], high_bound: high[NumberWidth-1:0]};
    do @(posedge clk_i); while (!req_ready_o);
    predict_sieve(low, high);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rsp_valid_o && rsp_ready_i) begin
      if (sieve_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", rsp_o);
      end else begin
        if (rsp_o !== sieve_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", sieve_words[0], rsp_o);
        end
        void'(sieve_words.pop_front());
      end
    end
  end

  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ready_i <= 1'b1;
      do @(posedge clk_i); while (!rsp_valid_o);
    end
  end

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    while (sieve_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_segment(bit wide);
    int unsigned low;
    int unsigned span;
    span = $urandom_range(1, SegmentLength);
    low = wide ? $urandom_range(0, MaxNum - span + 1) : $urandom_range(0, 60000);
    send_bounds(low, low + span - 1);
  endtask

  task automatic test_directed();
    send_bounds(0, 63);
    send_bounds(0, 0);
    send_bounds(1, 1);
    send_bounds(0, 1);
    send_bounds(2, 2);
    send_bounds(45, 60);
    send_bounds(5, 4);
    send_bounds(0, 64);
    send_bounds(0, MaxNum);
    send_bounds(MaxNum, 0);
    send_bounds(MaxNum, MaxNum);
    send_bounds(MaxNum - 63, MaxNum);
    send_bounds(4095 * 4095 - 10, 4095 * 4095 + 20);
    send_bounds(100, 163);
  endtask

  task automatic test_small_segments();
    repeat (25) random_segment(1'b0);
  endtask

  task automatic test_full_range();
    repeat (12) random_segment(1'b1);
  endtask

  task automatic test_range_errors();
    int unsigned low;
    repeat (20) begin
      low = $urandom_range(1, MaxNum);
      if ($urandom_range(0, 1)) send_bounds(low, $urandom_range(0, low - 1));
      else send_bounds($urandom_range(0, MaxNum - 64), $urandom);
    end
  endtask

  task automatic test_drained_pause();
    random_segment(1'b0);
    wait_drained();
    random_segment(1'b0);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (10) random_segment(1'b0);
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_small_segments();
    test_drained_pause();
    test_full_range();
    test_range_errors();
    test_back_to_back();
    test_small_segments();
    wait_drained();
    repeat (200) @(negedge clk_i);
    if (mismatches == 0 && sieve_words.size() == 0) begin
      $display("segmented_prime_sieve_unit test passed");
    end else begin
      $display("segmented_prime_sieve_unit test failed");
    end
    $finish;
  end
endmodule
